// ----- hdl/ebd_pkg.sv -----
// Shared constants for the energy beat detector: request codes, configuration
// register indexes, reset values and counter limits.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ebd_pkg;

	// request codes carried on req_type
	localparam logic REQ_BAND = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BEAT_FLOOR = 2'd1;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned LEVEL_W    = 16;
	localparam int unsigned OUT_SUM_W  = 20;

	localparam logic [CFG_DATA_W-1:0] MIN_GAP_RST    = 16'd500;
	localparam logic [CFG_DATA_W-1:0] BEAT_FLOOR_RST = 16'd4096;

	// millisecond counter, saturating
	localparam int unsigned ELAPSED_W = 17;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;

endpackage

`default_nettype wire

// ----- hdl/ebd_hist_cell.sv -----
// One cell of the history chain: holds one past frame sum and hands it on
// to the next cell when a new frame is pushed.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ebd_hist_cell #(
	parameter int unsigned SUM_W = 20
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             shift,
	input  wire logic [SUM_W-1:0] d,
	output logic      [SUM_W-1:0] q
);

	logic [SUM_W-1:0] sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (shift) begin
			sum_q <= d;
		end
	end

	assign q = sum_q;

endmodule

`default_nettype wire

// ----- hdl/ebd_hist_chain.sv -----
// History of past frame sums as a row of ebd_hist_cell, newest at the head,
// oldest at the tail, with the running total of all cells.
// Depends on ebd_hist_cell.
`timescale 1ns / 1ps
`default_nettype none

module ebd_hist_chain #(
	parameter int unsigned SUM_W = 20,
	parameter int unsigned DEPTH = 22,
	parameter int unsigned TOT_W = 25
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [SUM_W-1:0] push_sum,
	output logic      [TOT_W-1:0] total
);

	logic [SUM_W-1:0] tap [DEPTH+1];
	logic [TOT_W-1:0] total_q;

	assign tap[0] = push_sum;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		ebd_hist_cell #(
			.SUM_W(SUM_W)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (push),
			.d     (tap[i]),
			.q     (tap[i+1])
		);
	end

	// drop the oldest sum as the new one enters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (push) begin
			total_q <= total_q - TOT_W'(tap[DEPTH]) + TOT_W'(push_sum);
		end
	end

	assign total = total_q;

endmodule

`default_nettype wire

// ----- hdl/energy_beat_detector_core.sv -----
// Energy beat detector top level: frame accumulation, beat test, elapsed
// counter, configuration registers and output register.
// Depends on ebd_pkg and ebd_hist_chain.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, req_type, band_level  | sink
//  out     | out_valid, out_ready, beat, frame_sum     | source
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | sink
//
// One input transaction per cycle while in_ready is high; a frame's result
// is registered by the single accumulate-and-compare stage in the cycle
// after its last band level. Reset clears the frame, the history chain and
// the elapsed counter at once. in_ready drops only while a result waits and
// out_ready is low. Configuration writes are taken in every cycle.
`timescale 1ns / 1ps
`default_nettype none

module energy_beat_detector_core #(
	parameter int unsigned BANDS   = 12,
	parameter int unsigned HISTORY = 22
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             req_type,
	input  wire logic [ebd_pkg::LEVEL_W-1:0]      band_level,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  beat,
	output logic      [ebd_pkg::OUT_SUM_W-1:0]    frame_sum,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [ebd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ebd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import ebd_pkg::*;

	localparam int unsigned SUM_W  = LEVEL_W + $clog2(BANDS);
	localparam int unsigned TOT_W  = SUM_W + $clog2(HISTORY);
	localparam int unsigned PROD_W = TOT_W + 7;
	localparam int unsigned CNT_W  = $clog2(BANDS + 1);

	logic [CNT_W-1:0]      band_count_q;
	logic [SUM_W-1:0]      accum_q;
	logic [ELAPSED_W-1:0]  elapsed_q;
	logic [CFG_DATA_W-1:0] min_gap_q;
	logic [SUM_W-1:0]      floor_x_q;
	logic                  out_valid_q;
	logic                  beat_q;
	logic [SUM_W-1:0]      sum_q;

	logic                  in_fire;
	logic                  band_fire;
	logic                  tick_fire;
	logic                  frame_last;
	logic                  push;
	logic [SUM_W-1:0]      sum;
	logic [TOT_W-1:0]      total;
	logic [PROD_W-1:0]     lhs;
	logic [PROD_W-1:0]     rhs;
	logic                  louder;
	logic                  above_floor;
	logic                  gap_ok;
	logic                  beat_d;
	logic [SUM_W+OUT_SUM_W-1:0] sum_ext;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign band_fire = in_fire && (req_type == REQ_BAND);
	assign tick_fire = in_fire && (req_type == REQ_TICK);
	assign frame_last = (band_count_q == CNT_W'(BANDS - 1));
	assign push      = band_fire && frame_last;

	assign sum = accum_q + SUM_W'(band_level);

	// compare averages exactly by cross-multiplying
	assign lhs         = PROD_W'(sum) * PROD_W'(HISTORY);
	assign rhs         = PROD_W'(total) * PROD_W'(BANDS);
	assign louder      = lhs > rhs;
	assign above_floor = sum > floor_x_q;
	assign gap_ok      = elapsed_q > {1'b0, min_gap_q};
	assign beat_d      = louder && above_floor && gap_ok;

	ebd_hist_chain #(
		.SUM_W(SUM_W),
		.DEPTH(HISTORY),
		.TOT_W(TOT_W)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_sum(sum),
		.total   (total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_count_q <= '0;
			accum_q      <= '0;
		end else if (band_fire) begin
			if (frame_last) begin
				band_count_q <= '0;
				accum_q      <= '0;
			end else begin
				band_count_q <= band_count_q + CNT_W'(1);
				accum_q      <= sum;
			end
		end
	end

	// clear on a beat, otherwise count ticks up to the limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
		end else if (push && beat_d) begin
			elapsed_q <= '0;
		end else if (tick_fire && (elapsed_q != ELAPSED_MAX)) begin
			elapsed_q <= elapsed_q + ELAPSED_W'(1);
		end
	end

	// hold the floor pre-scaled by the band count
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q <= MIN_GAP_RST;
			floor_x_q <= SUM_W'(32'(BEAT_FLOOR_RST) * BANDS);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MIN_GAP: begin
					min_gap_q <= cfg_data;
				end
				CFG_BEAT_FLOOR: begin
					floor_x_q <= SUM_W'(32'(cfg_data) * BANDS);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			beat_q <= beat_d;
			sum_q  <= sum;
		end
	end

	assign sum_ext   = {{OUT_SUM_W{1'b0}}, sum_q};
	assign out_valid = out_valid_q;
	assign beat      = beat_q;
	assign frame_sum = sum_ext[OUT_SUM_W-1:0];

`ifndef SYNTH
	a_beat_clears_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		(push && beat_d) |=> (elapsed_q == '0))
		else $error("elapsed counter not cleared after a beat");

	a_frame_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (out_valid && (beat == $past(beat_d))))
		else $error("completed frame did not load the output register");

	a_band_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		band_count_q <= CNT_W'(BANDS - 1))
		else $error("band counter beyond the last band");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_energy_beat_detector_core.sv -----
// Self-checking testbench for energy_beat_detector_core: directed edge cases,
// minimum gap boundary, back-pressure and random frame phases.
// Depends on ebd_pkg and the RTL of the block; everything else lives here.
`timescale 1ns / 1ps

module tb_energy_beat_detector_core;
	import ebd_pkg::*;

	localparam int unsigned BANDS   = 12;
	localparam int unsigned HISTORY = 22;

	// indexes past the last register; writes there must have no effect
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	localparam int unsigned SETTLE_CYCLES = 4;

	typedef struct packed {
		logic                 beat;
		logic [OUT_SUM_W-1:0] frame_sum;
	} frame_result_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	logic                  req_type   = REQ_BAND;
	logic [LEVEL_W-1:0]    band_level = '0;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	logic                  beat;
	logic [OUT_SUM_W-1:0]  frame_sum;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = CFG_MIN_GAP;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	// predicted state of the detector
	logic [CFG_DATA_W-1:0] min_gap_m   = MIN_GAP_RST;
	logic [CFG_DATA_W-1:0] floor_m     = BEAT_FLOOR_RST;
	int unsigned           band_cnt_m  = 0;
	logic [OUT_SUM_W-1:0]  frame_acc_m = '0;
	logic [OUT_SUM_W-1:0]  hist_m [HISTORY];
	int unsigned           hist_ptr_m  = 0;
	logic [24:0]           hist_total_m = '0;
	logic [ELAPSED_W-1:0]  elapsed_m   = '0;

	frame_result_t pending_frames[$];
	int            mismatches   = 0;
	int            tx_idle_pct  = 0;
	int            rx_stall_pct = 0;
	int            hold_req     = 0;
	int            hold_left    = 0;

	energy_beat_detector_core #(
		.BANDS   (BANDS),
		.HISTORY (HISTORY)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.band_level (band_level),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.beat       (beat),
		.frame_sum  (frame_sum),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		for (int i = 0; i < HISTORY; i++) begin
			hist_m[i] = '0;
		end
	end

	// Advance the predicted detector by one accepted transaction.
	function automatic void step_beat_model(logic rt, logic [LEVEL_W-1:0] lvl);
		logic [OUT_SUM_W-1:0] sum;
		logic [OUT_SUM_W-1:0] old;
		logic                 louder;
		logic                 above_floor;
		logic                 gap_ok;
		frame_result_t        res;
		if (rt == REQ_TICK) begin
			if (elapsed_m != ELAPSED_MAX) begin
				elapsed_m = elapsed_m + 1'b1;
			end
			return;
		end
		frame_acc_m = frame_acc_m + lvl;
		band_cnt_m++;
		if (band_cnt_m < BANDS) begin
			return;
		end
		sum         = frame_acc_m;
		louder      = 64'(sum) * HISTORY > 64'(hist_total_m) * BANDS;
		above_floor = 64'(sum) > 64'(floor_m) * BANDS;
		gap_ok      = elapsed_m > 17'(min_gap_m);
		old = hist_m[hist_ptr_m];
		hist_m[hist_ptr_m] = sum;
		hist_total_m = hist_total_m - old + sum;
		hist_ptr_m = (hist_ptr_m + 1) % HISTORY;
		res.beat      = louder && above_floor && gap_ok;
		res.frame_sum = sum;
		if (res.beat) begin
			elapsed_m = '0;
		end
		band_cnt_m  = 0;
		frame_acc_m = '0;
		pending_frames.push_back(res);
	endfunction

	// Offer one item, idling first at the current rate; hold until accepted.
	task automatic offer_item(logic rt, logic [LEVEL_W-1:0] lvl);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= rt;
		band_level <= lvl;
		do @(posedge clk); while (!in_ready);
		step_beat_model(rt, lvl);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller drops it after its last write.
	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_MIN_GAP:    min_gap_m = data;
			CFG_BEAT_FLOOR: floor_m   = data;
			default: ;
		endcase
	endtask

	task automatic configure(logic [CFG_DATA_W-1:0] gap, logic [CFG_DATA_W-1:0] flr);
		wait_for_results();
		put_reg(CFG_MIN_GAP, gap);
		put_reg(CFG_BEAT_FLOOR, flr);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed_edges();
		configure(16'd0, 16'd0);
		@(posedge clk);
		put_reg(CFG_SPARE_LO, 16'hFFFF);
		put_reg(CFG_SPARE_HI, 16'h0000);
		cfg_valid <= 1'b0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		// tick with a level present: level must be ignored
		offer_item(REQ_TICK, 16'hFFFF);
		// loudest possible frame over an empty history: beat
		repeat (BANDS) offer_item(REQ_BAND, 16'hFFFF);
		// silent frame with a tick part way through: no beat
		repeat (BANDS / 2) offer_item(REQ_BAND, 16'h0000);
		offer_item(REQ_TICK, 16'h0000);
		repeat (BANDS - BANDS / 2) offer_item(REQ_BAND, 16'h0000);
		wait_for_results();
	endtask

	// Runs after the directed edges, which leave elapsed at one. A louder frame
	// with elapsed equal to the gap must not beat; one tick more lets the next beat.
	task automatic test_gap_boundary();
		configure(16'd20, 16'd0);
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		repeat (19) offer_item(REQ_TICK, 16'($urandom_range(16'hFFFF)));
		repeat (BANDS) offer_item(REQ_BAND, 16'h8C00);
		offer_item(REQ_TICK, 16'h0000);
		repeat (BANDS) offer_item(REQ_BAND, 16'hFFFF);
		wait_for_results();
	endtask

	task automatic test_random_phase(int n, logic [CFG_DATA_W-1:0] gap,
			logic [CFG_DATA_W-1:0] flr, int tx_pct, int rx_pct);
		int                 sent;
		int                 burst;
		int                 pick;
		logic [LEVEL_W-1:0] mask;
		logic [LEVEL_W-1:0] fill;
		sent = 0;
		mask = 16'hFFFF;
		fill = 16'h0000;
		configure(gap, flr);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		while (sent < n) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				burst = $urandom_range(24, 1);
				repeat (burst) offer_item(REQ_TICK, 16'($urandom_range(16'hFFFF)));
				sent += burst;
			end else if (pick < 14) begin
				offer_item(REQ_TICK, 16'($urandom_range(16'hFFFF)));
				sent++;
			end else begin
				// choose the loudness of each frame at its first band
				if (band_cnt_m == 0) begin
					fill = 16'h0000;
					case ($urandom_range(4))
						0: mask = 16'h00FF;
						1: mask = 16'h0FFF;
						2: mask = 16'h7FFF;
						3: mask = 16'hFFFF;
						default: fill = 16'hFFFF;
					endcase
				end
				offer_item(REQ_BAND, (16'($urandom_range(16'hFFFF)) & mask) | fill);
				sent++;
			end
		end
	endtask

	// Hold the output off long enough for the input to stall behind it.
	task automatic test_backpressure();
		configure(16'd0, 16'd0);
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_req = 60;
		repeat (3 * BANDS) offer_item(REQ_BAND, 16'($urandom_range(16'hFFFF)));
		wait_for_results();
	endtask

	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_frames.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual beat %0d frame_sum %0d",
					$time, beat, frame_sum);
				mismatches++;
			end else begin
				want = pending_frames.pop_front();
				if (beat !== want.beat) begin
					$display("%0t: beat mismatch, expected %0d, actual %0d",
						$time, want.beat, beat);
					mismatches++;
				end
				if (frame_sum !== want.frame_sum) begin
					$display("%0t: frame_sum mismatch, expected %0d, actual %0d",
						$time, want.frame_sum, frame_sum);
					mismatches++;
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_gap_boundary();
		test_random_phase(120, 16'd0,     16'd0,     0,  0);
		test_random_phase(120, 16'd3,     16'd2048,  66, 0);
		test_random_phase(120, 16'hFFFF,  16'hFFFF,  0,  66);
		test_random_phase(120, 16'd0,     16'hFFFF,  29, 29);
		test_random_phase(120, 16'd10,    16'd4096,  0,  0);
		test_random_phase(120, MIN_GAP_RST, BEAT_FLOOR_RST, 29, 29);
		test_backpressure();
		wait_for_results();
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
